FILE: hw/rtl/lbm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Layer blend mode package
// Mode codes, register indexes and reset values shared by the blend unit.
// ----------------------------------------------------------------------------
package lbm_pkg;

  localparam int CHANNEL_BITS_DEF = 8;
  localparam int CFG_ADDR_BITS    = 3;
  localparam int CFG_DATA_BITS    = 9;

  typedef enum logic [3:0] {
    MODE_NORMAL   = 4'd0,
    MODE_MULTIPLY = 4'd1,
    MODE_SCREEN   = 4'd2,
    MODE_OVERLAY  = 4'd3,
    MODE_ADD      = 4'd4,
    MODE_SUBTRACT = 4'd5,
    MODE_DIFF     = 4'd6,
    MODE_LIGHTEN  = 4'd7,
    MODE_DARKEN   = 4'd8,
    MODE_LINLIGHT = 4'd9,
    MODE_DODGE    = 4'd10
  } mode_t;

  localparam logic [CFG_ADDR_BITS-1:0] REG_MODE    = 3'd0;
  localparam logic [CFG_ADDR_BITS-1:0] REG_OPACITY = 3'd1;
  localparam logic [CFG_ADDR_BITS-1:0] REG_WR      = 3'd2;
  localparam logic [CFG_ADDR_BITS-1:0] REG_WG      = 3'd3;
  localparam logic [CFG_ADDR_BITS-1:0] REG_WB      = 3'd4;

  localparam logic [7:0] OPACITY_RST = 8'd255;
  localparam logic [8:0] WR_RST      = 9'd77;
  localparam logic [8:0] WG_RST      = 9'd150;
  localparam logic [8:0] WB_RST      = 9'd29;

endpackage

FILE: hw/rtl/layer_blend_mode_unit_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Layer blend mode unit
// Blends a top RGB pixel over a base pixel by a configured blend mode.
// ----------------------------------------------------------------------------
// One pixel pair can be taken every clock; each accepted word passes through
// the six register stages of the channel pipeline, two of which share the
// colour dodge division. While the last stage holds a word that the consumer
// stalls, the whole pipeline and the input stall; otherwise the pipeline
// advances every cycle.
module layer_blend_mode_unit_core #(
  parameter int CHANNEL_BITS = lbm_pkg::CHANNEL_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lbm_pkg::CFG_ADDR_BITS-1:0]   cfg_index,
  input  logic [lbm_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [CHANNEL_BITS-1:0]             top_red,
  input  logic [CHANNEL_BITS-1:0]             top_green,
  input  logic [CHANNEL_BITS-1:0]             top_blue,
  input  logic [CHANNEL_BITS-1:0]             base_red,
  input  logic [CHANNEL_BITS-1:0]             base_green,
  input  logic [CHANNEL_BITS-1:0]             base_blue,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [CHANNEL_BITS-1:0]             out_red,
  output logic [CHANNEL_BITS-1:0]             out_green,
  output logic [CHANNEL_BITS-1:0]             out_blue
);
  import lbm_pkg::*;

  localparam int N     = CHANNEL_BITS;
  localparam int DEPTH = 6;
  localparam int GW    = N + 12;

  logic [3:0] blend_mode;
  logic [7:0] opacity;
  logic [8:0] wr, wg, wb;
  logic [DEPTH-1:0] vld;
  logic en;
  logic [GW-1:0] gray;
  logic dark1;

  // Configuration registers.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      blend_mode <= MODE_NORMAL;
      opacity    <= OPACITY_RST;
      wr         <= WR_RST;
      wg         <= WG_RST;
      wb         <= WB_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MODE:    blend_mode <= cfg_data[3:0];
        REG_OPACITY: opacity    <= cfg_data[7:0];
        REG_WR:      wr         <= cfg_data;
        REG_WG:      wg         <= cfg_data;
        REG_WB:      wb         <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pipeline advances unless the last word is held by the consumer.
  assign en        = !(vld[DEPTH-1] && out_stall);
  assign in_stall  = !en;
  assign out_valid = vld[DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[DEPTH-2:0], in_valid};
  end

  // Gray key for overlay, registered with stage 1.
  assign gray = GW'(wr) * GW'(top_red) + GW'(wg) * GW'(top_green)
              + GW'(wb) * GW'(top_blue);
  always_ff @(posedge clk) begin
    if (en) dark1 <= ({gray, 1'b0} < (GW+1)'(256) * (GW+1)'({N{1'b1}}));
  end

  lbm_chan #(.CHANNEL_BITS(CHANNEL_BITS)) u_red (
    .clk(clk), .en(en), .mode(blend_mode), .opacity(opacity), .dark_s1(dark1),
    .a_in(top_red), .b_in(base_red), .res(out_red)
  );
  lbm_chan #(.CHANNEL_BITS(CHANNEL_BITS)) u_green (
    .clk(clk), .en(en), .mode(blend_mode), .opacity(opacity), .dark_s1(dark1),
    .a_in(top_green), .b_in(base_green), .res(out_green)
  );
  lbm_chan #(.CHANNEL_BITS(CHANNEL_BITS)) u_blue (
    .clk(clk), .en(en), .mode(blend_mode), .opacity(opacity), .dark_s1(dark1),
    .a_in(top_blue), .b_in(base_blue), .res(out_blue)
  );

endmodule

FILE: hw/rtl/lbm_chan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Layer blend channel pipeline
// Six-stage blend of one colour channel; the stall enable is shared.
// ----------------------------------------------------------------------------
module lbm_chan #(
  parameter int CHANNEL_BITS = lbm_pkg::CHANNEL_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic [3:0]              mode,
  input  logic [7:0]              opacity,
  input  logic                    dark_s1,
  input  logic [CHANNEL_BITS-1:0] a_in,
  input  logic [CHANNEL_BITS-1:0] b_in,
  output logic [CHANNEL_BITS-1:0] res
);
  import lbm_pkg::*;

  localparam int N  = CHANNEL_BITS;
  localparam int PW = 2 * N + 2;
  localparam int MW = N + 10;
  localparam int DW = 2 * N + 1;
  localparam int XW = 3 * N + 3;
  localparam int VW = MW + 9;
  localparam int LO = N / 2;
  localparam logic [N-1:0]  MAXV = {N{1'b1}};
  localparam logic [PW-1:0] HALF = PW'(MAXV >> 1);
  localparam logic [PW-1:0] MAXP = PW'(MAXV);

  // Stage 1 registers: operands and the opacity product of the base.
  logic [N-1:0]  a1, b1;
  logic [N+7:0]  bop1;
  // Stage 2: products that feed the rounded divides, and the dodge divisor.
  logic [N-1:0]  a2, b2;
  logic [PW-1:0] pm2, ps2, po2;
  logic [N-1:0]  d2;
  logic          dark2;
  // Stage 3: raw result, dodge divisor and numerator.
  logic [N-1:0]  a3, b3, r3;
  logic          mixed3, dz3;
  logic [N-1:0]  d3;
  logic [DW-1:0] num3;
  // Stage 4: mix sum and the upper half of the dodge quotient.
  logic [N-1:0]  a4, d4, r4, rem4, q4;
  logic [LO-1:0] lo4;
  logic          dz4, sat4, mixed4;
  logic [MW-1:0] mx4;
  // Stage 5: dodge result or raw result, mix sum carried.
  logic [N-1:0]  out5;
  logic [MW-1:0] mx5;
  logic          mixed5;

  // Rounded divide by the channel maximum: x/(2^N-1) equals
  // x*(2^N+1)/(2^2N-1), and the latter is a shift and add.
  function automatic logic [PW-1:0] divm(input logic [PW-1:0] x);
    logic [XW-1:0] s, y;
    s = XW'(x) + XW'(HALF);
    y = (s << N) + s;
    return PW'((y + (y >> (2 * N)) + XW'(1)) >> (2 * N));
  endfunction

  // Divide by 255 in the same way, through 255*257 = 2^16-1.
  function automatic logic [N-1:0] div255(input logic [MW-1:0] x);
    logic [VW-1:0] y;
    y = (VW'(x) << 8) + VW'(x);
    return N'((y + (y >> 16) + VW'(1)) >> 16);
  endfunction

  // Stage 1: base times opacity.
  always_ff @(posedge clk) begin
    if (en) begin
      a1   <= a_in;
      b1   <= b_in;
      bop1 <= (N+8)'(b_in) * (N+8)'(opacity);
    end
  end

  // Stage 2: the three products and the dodge divisor.
  always_ff @(posedge clk) begin
    if (en) begin
      a2    <= a1;
      b2    <= b1;
      dark2 <= dark_s1;
      d2    <= MAXV - div255(MW'(bop1) + MW'(127));
      pm2   <= PW'(a1) * PW'(b1);
      ps2   <= PW'(MAXV - a1) * PW'(MAXV - b1);
      po2   <= (PW'(MAXV - a1) * PW'(MAXV - b1)) << 1;
    end
  end

  // Stage 3: raw result per mode.
  always_ff @(posedge clk) begin
    logic [N-1:0]  mm, sm, t, r;
    logic [PW-1:0] tw;
    logic [N+2:0]  pos;
    logic [N+1:0]  h;
    logic          mixed;
    if (en) begin
      mm  = N'(divm(pm2));
      sm  = N'(divm(ps2));
      tw  = divm(po2);
      t   = N'(tw);
      pos = (N+3)'({b2, 1'b0}) + (N+3)'({a2, 2'b0});
      h   = (N+2)'(((N+3)'(pos - (N+3)'(MAXV)) + 1'b1) >> 1);
      mixed = 1'b1;
      r     = b2;
      case (mode)
        MODE_NORMAL:   r = a2;
        MODE_MULTIPLY: r = mm;
        MODE_SCREEN:   r = MAXV - sm;
        MODE_OVERLAY:  r = dark2 ? mm : ((tw > MAXP) ? '0 : MAXV - t);
        MODE_ADD:      r = ((N+1)'(a2) + (N+1)'(b2) > (N+1)'(MAXV)) ?
                           MAXV : a2 + b2;
        MODE_SUBTRACT: r = (a2 > b2) ? a2 - b2 : '0;
        MODE_LINLIGHT: r = (pos < (N+3)'(MAXV)) ? '0 :
                           ((h > (N+2)'(MAXV)) ? MAXV : N'(h));
        MODE_DIFF: begin
          r     = (a2 > b2) ? a2 - b2 : b2 - a2;
          mixed = 1'b0;
        end
        MODE_LIGHTEN: begin
          r     = (a2 > b2) ? a2 : b2;
          mixed = 1'b0;
        end
        MODE_DARKEN: begin
          r     = (a2 < b2) ? a2 : b2;
          mixed = 1'b0;
        end
        MODE_DODGE: mixed = 1'b0;
        default: mixed = 1'b0;
      endcase
      a3     <= a2;
      b3     <= b2;
      r3     <= r;
      mixed3 <= mixed;
      d3     <= d2;
      dz3    <= (d2 == '0);
      num3   <= DW'(a2) * DW'(MAXV) + DW'(d2 >> 1);
    end
  end

  // Stage 4: mix sum, saturation test and upper dodge quotient bits.
  // A quotient of 2^N or more saturates, so only N restoring steps are needed.
  always_ff @(posedge clk) begin
    logic [N:0]   rem;
    logic [N-1:0] q;
    if (en) begin
      rem = num3[DW-1:N];
      q   = '0;
      for (int i = N - 1; i >= LO; i--) begin
        rem = {rem[N-1:0], num3[i]};
        if (rem >= (N+1)'(d3)) begin
          rem  = rem - (N+1)'(d3);
          q[i] = 1'b1;
        end
      end
      a4     <= a3;
      d4     <= d3;
      dz4    <= dz3;
      sat4   <= (num3 >= DW'({d3, {N{1'b0}}}));
      rem4   <= rem[N-1:0];
      q4     <= q;
      lo4    <= num3[LO-1:0];
      r4     <= r3;
      mixed4 <= mixed3;
      mx4    <= MW'(b3) * MW'(8'd255 - opacity) + MW'(r3) * MW'(opacity) + MW'(127);
    end
  end

  // Stage 5: lower dodge quotient bits and the dodge special cases.
  always_ff @(posedge clk) begin
    logic [N:0]   rem;
    logic [N-1:0] q;
    if (en) begin
      rem = {1'b0, rem4};
      q   = q4;
      for (int i = LO - 1; i >= 0; i--) begin
        rem = {rem[N-1:0], lo4[i]};
        if (rem >= (N+1)'(d4)) begin
          rem  = rem - (N+1)'(d4);
          q[i] = 1'b1;
        end
      end
      mixed5 <= mixed4;
      mx5    <= mx4;
      if (mode == MODE_DODGE) begin
        if (dz4)       out5 <= (a4 == '0) ? '0 : MAXV;
        else if (sat4) out5 <= MAXV;
        else           out5 <= q;
      end else begin
        out5 <= r4;
      end
    end
  end

  // Stage 6: divide the mix by 255, or pass the stage 5 result through.
  always_ff @(posedge clk) begin
    if (en) res <= mixed5 ? div255(mx5) : out5;
  end

endmodule

FILE: tb/layer_blend_mode_unit_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Layer blend mode unit testbench
// Drives pixel pairs through the blend unit under every mode and several
// opacity and gray weight settings, predicts each blended word and checks it
// field by field, with random idling on both sides and one long output hold.
// ----------------------------------------------------------------------------
module layer_blend_mode_unit_core_tb;
  import lbm_pkg::*;

  localparam int CB = 8;
  localparam int CMAX = (1 << CB) - 1;
  localparam int CHALF = CMAX >> 1;
  localparam int LATENCY = 6;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [CB-1:0] r;
    logic [CB-1:0] g;
    logic [CB-1:0] b;
  } pixel_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_ADDR_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [CB-1:0] top_red = '0, top_green = '0, top_blue = '0;
  logic [CB-1:0] base_red = '0, base_green = '0, base_blue = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [CB-1:0] out_red, out_green, out_blue;

  // Shadow copy of the configuration registers.
  logic [3:0] cur_mode;
  logic [7:0] cur_opacity;
  logic [8:0] cur_wr, cur_wg, cur_wb;

  pixel_t blended_q[$];
  int errors = 0;
  longint cycles = 0;
  bit hold_long = 1'b0;
  bit rand_out_idle = 1'b1;
  int out_wait = 0;

  layer_blend_mode_unit_core #(.CHANNEL_BITS(CB)) uut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("layer_blend_mode_unit_core_tb NOT OK");
      $finish;
    end
  end

  function automatic int round_mul(int x, int y);
    return (x * y + CHALF) / CMAX;
  endfunction

  function automatic int op_mix(int b, int r);
    return (b * (255 - cur_opacity) + r * cur_opacity + 127) / 255;
  endfunction

  // Blend of one channel; returns the final value, with the opacity mix for the mixed modes.
  function automatic int blend_channel(bit dark, int a, int b);
    int r, t, v, d, q;
    case (cur_mode)
      MODE_NORMAL:   r = a;
      MODE_MULTIPLY: r = round_mul(a, b);
      MODE_SCREEN:   r = CMAX - round_mul(CMAX - a, CMAX - b);
      MODE_OVERLAY: begin
        if (dark) begin
          r = round_mul(a, b);
        end else begin
          t = (2 * (CMAX - a) * (CMAX - b) + CHALF) / CMAX;
          r = (t > CMAX) ? 0 : CMAX - t;
        end
      end
      MODE_ADD:      r = (a + b > CMAX) ? CMAX : a + b;
      MODE_SUBTRACT: r = (a > b) ? a - b : 0;
      MODE_DIFF:     return (a > b) ? a - b : b - a;
      MODE_LIGHTEN:  return (a > b) ? a : b;
      MODE_DARKEN:   return (a < b) ? a : b;
      MODE_LINLIGHT: begin
        v = 2 * b + 4 * a;
        if (v < CMAX) begin
          r = 0;
        end else begin
          r = (v - CMAX + 1) >> 1;
          if (r > CMAX) r = CMAX;
        end
      end
      MODE_DODGE: begin
        d = CMAX - (b * cur_opacity + 127) / 255;
        if (d == 0) return (a == 0) ? 0 : CMAX;
        q = (a * CMAX + (d >> 1)) / d;
        return (q > CMAX) ? CMAX : q;
      end
      default: return b;
    endcase
    return op_mix(b, r);
  endfunction

  function automatic pixel_t blend_pixel(pixel_t tp, pixel_t bp);
    pixel_t res;
    longint g2;
    bit dark;
    g2 = 2 * (longint'(cur_wr) * tp.r + longint'(cur_wg) * tp.g + longint'(cur_wb) * tp.b);
    dark = g2 < 256 * CMAX;
    res.r = CB'(blend_channel(dark, tp.r, bp.r));
    res.g = CB'(blend_channel(dark, tp.g, bp.g));
    res.b = CB'(blend_channel(dark, tp.b, bp.b));
    return res;
  endfunction

  // Sends one pixel pair, after a random gap when idle is set, and records its blended word.
  task automatic send_pixel(pixel_t tp, pixel_t bp, bit idle = 1'b1);
    int gap;
    gap = idle ? $urandom_range(0, 14) : 0;
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    {top_red, top_green, top_blue} <= tp;
    {base_red, base_green, base_blue} <= bp;
    blended_q.push_back(blend_pixel(tp, bp));
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic finish_sending();
    in_valid <= 1'b0;
  endtask

  // Stops sending and waits until every word has come back and the pipeline has emptied.
  task automatic drain();
    finish_sending();
    while (blended_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  // Writes one register; dropping cfg_valid after it keeps writes apart.
  task automatic write_reg(logic [CFG_ADDR_BITS-1:0] idx, int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_BITS'(value);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_MODE:    cur_mode = 4'(value);
      REG_OPACITY: cur_opacity = 8'(value);
      REG_WR:      cur_wr = 9'(value);
      REG_WG:      cur_wg = 9'(value);
      REG_WB:      cur_wb = 9'(value);
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic pixel_t rand_pixel();
    pixel_t p;
    case ($urandom_range(0, 5))
      0: p = '0;
      1: p = '1;
      default: p = 24'($urandom);
    endcase
    return p;
  endfunction

  // Output side: a random wait drawn per word, one long hold when asked, or no stall when random idling is off.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      out_wait = 0;
    end else if (hold_long) begin
      out_stall <= 1'b1;
    end else if (!rand_out_idle) begin
      out_wait = 0;
      out_stall <= 1'b0;
    end else if (out_valid && !out_stall) begin
      out_wait = $urandom_range(0, 14);
      out_stall <= (out_wait != 0);
    end else if (out_wait > 0) begin
      out_wait--;
      out_stall <= (out_wait != 0);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Checks each accepted word against the oldest expected blend.
  always @(posedge clk) begin
    pixel_t want;
    if (!rst && out_valid && !out_stall) begin
      if (blended_q.size() == 0) begin
        $error("unexpected word: %0d %0d %0d", out_red, out_green, out_blue);
        errors++;
      end else begin
        want = blended_q.pop_front();
        if (out_red !== want.r) begin
          $error("out_red expected %0d got %0d", want.r, out_red);
          errors++;
        end
        if (out_green !== want.g) begin
          $error("out_green expected %0d got %0d", want.g, out_green);
          errors++;
        end
        if (out_blue !== want.b) begin
          $error("out_blue expected %0d got %0d", want.b, out_blue);
          errors++;
        end
      end
    end
  end

  // Every mode and one unused code at reset settings with extreme and mixed channels.
  task automatic test_directed_modes();
    pixel_t ext[4];
    ext[0] = '0; ext[1] = '1; ext[2] = {8'd128, 8'd127, 8'd1}; ext[3] = {8'd254, 8'd1, 8'd0};
    for (int m = 0; m <= 11; m++) begin
      write_reg(REG_MODE, m);
      send_pixel(ext[m % 4], ext[(m + 1) % 4]);
      send_pixel(ext[(m + 2) % 4], ext[(m + 3) % 4], 1'b0);
      drain();
    end
  endtask

  // Dodge with a zero denominator, and overlay with gray keys above the split.
  task automatic test_special_cases();
    write_reg(REG_MODE, MODE_DODGE);
    write_reg(REG_OPACITY, 255);
    send_pixel('0, '1);
    send_pixel({8'd5, 8'd0, 8'd255}, '1);
    drain();
    write_reg(REG_MODE, MODE_OVERLAY);
    send_pixel({8'd127, 8'd128, 8'd127}, {8'd10, 8'd200, 8'd255});
    send_pixel({8'd128, 8'd128, 8'd128}, {8'd10, 8'd200, 8'd0});
    drain();
    write_reg(REG_WR, 511);
    write_reg(REG_WG, 511);
    write_reg(REG_WB, 511);
    send_pixel('1, '0);
    drain();
  endtask

  // Random pixels under a spread of configurations, extremes included.
  task automatic test_random_configs();
    int op_vals[4] = '{0, 255, 1, 128};
    int w_vals[4] = '{0, 256, 511, 77};
    for (int phase = 0; phase < 16; phase++) begin
      write_reg(REG_MODE, (phase < 11) ? phase : $urandom_range(0, 15));
      write_reg(REG_OPACITY, (phase < 4) ? op_vals[phase] : $urandom_range(0, 255));
      write_reg(REG_WR, (phase < 4) ? w_vals[phase] : $urandom_range(0, 511));
      write_reg(REG_WG, (phase < 4) ? w_vals[3 - phase] : $urandom_range(0, 511));
      write_reg(REG_WB, (phase < 4) ? w_vals[phase] : $urandom_range(0, 511));
      write_reg(CFG_ADDR_BITS'($urandom_range(5, 7)), $urandom_range(0, 511));
      rand_out_idle = (phase % 5 != 4);
      for (int k = 0; k < 45; k++)
        send_pixel(rand_pixel(), rand_pixel(), phase % 5 != 3);
      drain();
    end
  endtask

  // Output held off for a long stretch while input keeps coming.
  task automatic test_backpressure();
    write_reg(REG_MODE, MODE_SCREEN);
    fork
      begin
        hold_long = 1'b1;
        repeat (60) @(posedge clk);
        hold_long = 1'b0;
      end
      for (int k = 0; k < 40; k++) send_pixel(rand_pixel(), rand_pixel(), 1'b0);
    join
    drain();
  endtask

  initial begin
    cur_mode = 0;
    cur_opacity = OPACITY_RST;
    cur_wr = WR_RST;
    cur_wg = WG_RST;
    cur_wb = WB_RST;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_modes();
    test_special_cases();
    test_random_configs();
    test_backpressure();
    if (errors == 0 && blended_q.size() == 0) begin
      $display("layer_blend_mode_unit_core_tb OK");
    end else begin
      $display("layer_blend_mode_unit_core_tb NOT OK");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/lbm_pkg.sv
hw/rtl/lbm_chan.sv
hw/rtl/layer_blend_mode_unit_core.sv
tb/layer_blend_mode_unit_core_tb.sv
